### design/bilinear_stream_scaler_unit_defines.svh
// Assertion macros shared by the scaler RTL.
// Included by the top level; depends on nothing else.
`ifndef BILINEAR_STREAM_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_STREAM_SCALER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bss_pkg.sv
// Types, constants and arithmetic helpers of the bilinear stream scaler.
// Used by bss_csr and the top level of the block; depends on nothing.
`default_nettype none

package bss_pkg;

   localparam int AccW      = 28;
   localparam int SizeW     = 13;
   localparam int PosW      = 12;
   localparam int ChanW     = 8;
   localparam int PixW      = 3 * ChanW;
   localparam int EntryW    = 2 * PixW;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;

   localparam logic [AccW-1:0]  AccMax      = 28'hFFF_FFFF;
   localparam logic [PosW-1:0]  RowCountMax = 12'hFFF;
   localparam logic [SizeW-1:0] SizeMaxAll  = 13'd4096;
   localparam logic [8:0]       WeightOne   = 9'd256;

   typedef enum logic [2:0] {
      REG_SOURCE_WIDTH  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_TARGET_WIDTH  = 3'd2,
      REG_TARGET_HEIGHT = 3'd3,
      REG_COLUMN_STEP   = 3'd4,
      REG_ROW_STEP      = 3'd5,
      REG_SWAP_ORDER    = 3'd6,
      REG_UNUSED        = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic             frame_start;
      logic [ChanW-1:0] in_chan0;
      logic [ChanW-1:0] in_chan1;
      logic [ChanW-1:0] in_chan2;
   } req_item_type;

   typedef struct packed {
      logic [PosW-1:0]  dest_col;
      logic [PosW-1:0]  dest_row;
      logic [ChanW-1:0] out_chan0;
      logic [ChanW-1:0] out_chan1;
      logic [ChanW-1:0] out_chan2;
      logic             last_of_run;
   } rsp_item_type;

   // Clamped sizes and raw steps as the datapath sees them.
   typedef struct packed {
      logic [SizeW-1:0] src_w;
      logic [SizeW-1:0] src_h;
      logic [SizeW-1:0] dst_w;
      logic [SizeW-1:0] dst_h;
      logic [AccW-1:0]  col_step;
      logic [AccW-1:0]  row_step;
      logic             swap;
   } cfg_type;

   function automatic logic [AccW-1:0] acc_add(logic [AccW-1:0] a, logic [AccW-1:0] s);
      logic [AccW:0] t;
      t = {1'b0, a} + {1'b0, s};
      return t[AccW] ? AccMax : t[AccW-1:0];
   endfunction

   // Lower source row of a vertical position, clamped to the last row.
   function automatic logic [SizeW-1:0] lower_row(logic [AccW-1:0] acc,
                                                  logic [SizeW-1:0] sh);
      logic [SizeW-1:0] s;
      logic [SizeW-1:0] lim;
      s   = {1'b0, acc[AccW-1:16]} + 13'd1;
      lim = sh - 13'd1;
      return (s > lim) ? lim : s;
   endfunction

   // (a*(256-w) + b*w) >> 8; the sum never reaches 2^16.
   function automatic logic [ChanW-1:0] blend(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                              logic [ChanW-1:0] w);
      logic [8:0]  inv;
      logic [16:0] sum;
      inv = WeightOne - {1'b0, w};
      sum = ({9'd0, a} * {8'd0, inv}) + ({9'd0, b} * {9'd0, w});
      return sum[15:8];
   endfunction

   function automatic logic [ChanW-1:0] pick_chan(logic [PixW-1:0] px, logic [1:0] sel);
      logic [ChanW-1:0] v;
      unique case (sel)
         2'd0:    v = px[7:0];
         2'd1:    v = px[15:8];
         default: v = px[23:16];
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### design/bss_stream_if.sv
// Valid/ready stream channel carrying one payload type.
// Payload types come from bss_pkg.
`default_nettype none

interface bss_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/bss_line_store.sv
// Two-line pixel store: each entry holds the upper and lower row pixel of a column.
// One write port, two registered read ports; uses bss_pkg widths only through parameters.
`default_nettype none

module bss_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [DW-1:0] rd_data_a,
   output logic      [DW-1:0] rd_data_b
);

   logic [DW-1:0] line_mem_ff [DEPTH];
   logic [DW-1:0] rd_data_a_ff;
   logic [DW-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= line_mem_ff[rd_addr_a];
         rd_data_b_ff <= line_mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

### design/bss_csr.sv
// APB-style register file of the scaler, with size clamping.
// Depends on bss_pkg for register indexes and the cfg_type bundle.
`default_nettype none

module bss_csr #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bss_pkg::CsrAddrW-1:0]  paddr,
   input  wire logic [bss_pkg::CsrDataW-1:0]  pwdata,
   output logic      [bss_pkg::CsrDataW-1:0]  prdata,
   output bss_pkg::cfg_type                   cfg
);
   import bss_pkg::*;

   localparam logic [SizeW:0] MaxLineW = (SizeW + 1)'(MAX_LINE);

   logic [SizeW-1:0] src_w_ff, src_w_in;
   logic [SizeW-1:0] src_h_ff, src_h_in;
   logic [SizeW-1:0] dst_w_ff, dst_w_in;
   logic [SizeW-1:0] dst_h_ff, dst_h_in;
   logic [AccW-1:0]  col_step_ff, col_step_in;
   logic [AccW-1:0]  row_step_ff, row_step_in;
   logic             swap_ff, swap_in;
   reg_index_type    index;
   logic             wr_fire;

   function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v, logic [SizeW:0] hi);
      logic [SizeW:0] r;
      if (v < 13'd2) begin
         r = 14'd2;
      end else if ({1'b0, v} > hi) begin
         r = hi;
      end else begin
         r = {1'b0, v};
      end
      return r[SizeW-1:0];
   endfunction

   assign index   = reg_index_type'(paddr[4:2]);
   assign wr_fire = psel && penable && pwrite;

   always_comb begin
      src_w_in    = src_w_ff;
      src_h_in    = src_h_ff;
      dst_w_in    = dst_w_ff;
      dst_h_in    = dst_h_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      swap_in     = swap_ff;
      if (wr_fire) begin
         unique case (index)
            REG_SOURCE_WIDTH:  src_w_in    = pwdata[SizeW-1:0];
            REG_SOURCE_HEIGHT: src_h_in    = pwdata[SizeW-1:0];
            REG_TARGET_WIDTH:  dst_w_in    = pwdata[SizeW-1:0];
            REG_TARGET_HEIGHT: dst_h_in    = pwdata[SizeW-1:0];
            REG_COLUMN_STEP:   col_step_in = pwdata[AccW-1:0];
            REG_ROW_STEP:      row_step_in = pwdata[AccW-1:0];
            REG_SWAP_ORDER:    swap_in     = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= 13'd640;
         src_h_ff    <= 13'd480;
         dst_w_ff    <= 13'd640;
         dst_h_ff    <= 13'd480;
         col_step_ff <= 28'd65536;
         row_step_ff <= 28'd65536;
         swap_ff     <= 1'b0;
      end else begin
         src_w_ff    <= src_w_in;
         src_h_ff    <= src_h_in;
         dst_w_ff    <= dst_w_in;
         dst_h_ff    <= dst_h_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
         swap_ff     <= swap_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_SOURCE_WIDTH:  prdata = 32'(src_w_ff);
         REG_SOURCE_HEIGHT: prdata = 32'(src_h_ff);
         REG_TARGET_WIDTH:  prdata = 32'(dst_w_ff);
         REG_TARGET_HEIGHT: prdata = 32'(dst_h_ff);
         REG_COLUMN_STEP:   prdata = 32'(col_step_ff);
         REG_ROW_STEP:      prdata = 32'(row_step_ff);
         REG_SWAP_ORDER:    prdata = 32'(swap_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.src_w    = clamp_size(src_w_ff, MaxLineW);
   assign cfg.src_h    = clamp_size(src_h_ff, {1'b0, SizeMaxAll});
   assign cfg.dst_w    = clamp_size(dst_w_ff, {1'b0, SizeMaxAll});
   assign cfg.dst_h    = clamp_size(dst_h_ff, {1'b0, SizeMaxAll});
   assign cfg.col_step = col_step_ff;
   assign cfg.row_step = row_step_ff;
   assign cfg.swap     = swap_ff;

endmodule

`default_nettype wire

### design/bilinear_stream_scaler_unit.sv
// Top level of the bilinear stream scaler: sequencer, blend datapath, output register.
// Depends on bss_pkg, bss_stream_if, bss_line_store, bss_csr and the defines header.
//
//   Channel   Direction  Payload                                   Handshake
//   req_if    in         frame_start, in_chan0..in_chan2           valid / ready
//   rsp_if    out        dest_col, dest_row, out_chan0..2, last    valid / ready
//   csr_*     in/out     seven registers at byte address 4*index   APB, pready high
//
// Each request passes through the line store read, load and commit steps;
// at any column but the first, column steps between load and commit advance
// the destination columns, with a horizontal and a vertical blend step per
// result. The last column of a source row adds finish steps that close the
// destination rows. The line store is read once and written once per request.
// Reset is synchronous and clears the sequencer state, the frame position
// counters and the fanout count, not the working registers; the line store is
// not cleared. A stalled result channel holds the sequencer in the vertical
// blend step; requests are taken only when the sequencer is idle.
`default_nettype none
`include "bilinear_stream_scaler_unit_defines.svh"

module bilinear_stream_scaler_unit #(
   parameter int MAX_LINE   = 4096,
   parameter int MAX_FANOUT = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bss_stream_if.sink                         req_if,
   bss_stream_if.source                       rsp_if,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bss_pkg::CsrAddrW-1:0]  csr_paddr,
   input  wire logic [bss_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic      [bss_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import bss_pkg::*;

   localparam int LineAw = $clog2(MAX_LINE);
   localparam int FanW   = $clog2(MAX_FANOUT + 1);
   localparam logic [FanW-1:0] FanMax = FanW'(MAX_FANOUT);

   // One-hot sequencer states.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_LOAD   = 8'b0000_0100,
      ST_COLS   = 8'b0000_1000,
      ST_EMIT_H = 8'b0001_0000,
      ST_EMIT_V = 8'b0010_0000,
      ST_COMMIT = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   cfg_type cfg;

   state_type        state_ff, state_in;
   logic [PixW-1:0]  px_ff, px_in;
   logic [LineAw-1:0] cur_c_ff, cur_c_in;
   logic [PosW-1:0]  cur_r_ff, cur_r_in;
   logic [LineAw-1:0] src_col_ff, src_col_in;
   logic [PosW-1:0]  src_row_ff, src_row_in;
   logic [SizeW-1:0] grp_row_ff, grp_row_in;
   logic [AccW-1:0]  grp_acc_ff, grp_acc_in;
   logic [SizeW-1:0] ndc_ff, ndc_in;
   logic [AccW-1:0]  col_acc_ff, col_acc_in;
   logic [AccW-1:0]  wa_ff, wa_in;
   logic [SizeW-1:0] wk_ff, wk_in;
   logic [SizeW-1:0] wdy_ff, wdy_in;
   logic [AccW-1:0]  wra_ff, wra_in;
   logic [SizeW-1:0] wj_ff, wj_in;
   logic [AccW-1:0]  wca_ff, wca_in;
   logic [FanW-1:0]  wn_ff, wn_in;
   logic [PixW-1:0]  tap_up_c_ff, tap_up_c_in;
   logic [PixW-1:0]  tap_up_cm1_ff, tap_up_cm1_in;
   logic [PixW-1:0]  tap_lo_cm1_ff, tap_lo_cm1_in;
   logic [ChanW-1:0] ht_ff [3];
   logic [ChanW-1:0] ht_in [3];
   logic [ChanW-1:0] hb_ff [3];
   logic [ChanW-1:0] hb_in [3];
   logic [ChanW-1:0] wy_ff, wy_in;
   logic [PosW-1:0]  dcol_ff, dcol_in;
   logic [PosW-1:0]  drow_ff, drow_in;
   logic             more_ff, more_in;
   logic             col_more_ff, col_more_in;
   logic [AccW-1:0]  ra_n_ff, ra_n_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [LineAw-1:0] mem_rd_addr_b;
   logic [EntryW-1:0] mem_wr_data;
   logic [EntryW-1:0] mem_rd_a;
   logic [EntryW-1:0] mem_rd_b;

   logic              req_fire;
   logic              out_free;
   logic [13:0]       c_ext;
   logic [13:0]       sw_m1;
   logic [13:0]       tap_col;
   logic              col_cond;
   logic              row_cond;
   logic [SizeW-1:0]  sy0;
   logic [SizeW-1:0]  sh_m1;
   logic              use_lower;
   logic [PixW-1:0]   top_c;
   logic [PixW-1:0]   top_cm1;
   logic [AccW-1:0]   ra_step;
   logic              row_more;
   logic [1:0]        sel [3];

   bss_csr #(.MAX_LINE(MAX_LINE)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   // Entry layout: upper row pixel in the high half, lower row pixel in the low half.
   bss_line_store #(.DEPTH(MAX_LINE), .AW(LineAw), .DW(EntryW)) u_line_store (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (cur_c_ff),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (cur_c_ff),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_a),
      .rd_data_b (mem_rd_b)
   );

   assign mem_rd_en     = (state_ff == ST_READ);
   assign mem_rd_addr_b = (cur_c_ff == '0) ? '0 : cur_c_ff - LineAw'(1);
   assign mem_wr_en     = (state_ff == ST_LOAD);
   // The old lower pixel moves up; the new request pixel becomes the lower one.
   assign mem_wr_data   = {mem_rd_a[PixW-1:0], px_ff};

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Column advance test: the destination column's left tap lies left of this column.
   assign c_ext    = 14'(cur_c_ff);
   assign sw_m1    = {1'b0, cfg.src_w - 13'd1};
   assign tap_col  = ({2'b0, wa_ff[AccW-1:16]} > {1'b0, cfg.src_w - 13'd2})
                     ? {1'b0, cfg.src_w - 13'd2} : {2'b0, wa_ff[AccW-1:16]};
   assign col_cond = (({1'b0, ndc_ff} + {1'b0, wk_ff}) < {1'b0, cfg.dst_w})
                     && (tap_col < c_ext);

   // Row test: the destination row's lower tap row has already arrived.
   assign row_cond = (wdy_ff < cfg.dst_h)
                     && (lower_row(wra_ff, cfg.src_h) <= {1'b0, cur_r_ff});

   assign sh_m1     = cfg.src_h - 13'd1;
   assign sy0       = ({1'b0, wra_ff[AccW-1:16]} > sh_m1) ? sh_m1 : {1'b0, wra_ff[AccW-1:16]};
   assign use_lower = (sy0 >= {1'b0, cur_r_ff});
   assign top_c     = use_lower ? px_ff : tap_up_c_ff;
   assign top_cm1   = use_lower ? tap_lo_cm1_ff : tap_up_cm1_ff;
   assign ra_step   = acc_add(wra_ff, cfg.row_step);
   assign row_more  = ((wdy_ff + 13'd1) < cfg.dst_h)
                      && (lower_row(ra_step, cfg.src_h) <= {1'b0, cur_r_ff});

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sel[ch] = cfg.swap ? 2'(2 - ch) : 2'(ch);
      end
   end

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      cur_c_in      = cur_c_ff;
      cur_r_in      = cur_r_ff;
      src_col_in    = src_col_ff;
      src_row_in    = src_row_ff;
      grp_row_in    = grp_row_ff;
      grp_acc_in    = grp_acc_ff;
      ndc_in        = ndc_ff;
      col_acc_in    = col_acc_ff;
      wa_in         = wa_ff;
      wk_in         = wk_ff;
      wdy_in        = wdy_ff;
      wra_in        = wra_ff;
      wj_in         = wj_ff;
      wca_in        = wca_ff;
      wn_in         = wn_ff;
      tap_up_c_in   = tap_up_c_ff;
      tap_up_cm1_in = tap_up_cm1_ff;
      tap_lo_cm1_in = tap_lo_cm1_ff;
      wy_in         = wy_ff;
      dcol_in       = dcol_ff;
      drow_in       = drow_ff;
      more_in       = more_ff;
      col_more_in   = col_more_ff;
      ra_n_in       = ra_n_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      for (int ch = 0; ch < 3; ch++) begin
         ht_in[ch] = ht_ff[ch];
         hb_in[ch] = hb_ff[ch];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               px_in = {req_if.data.in_chan2, req_if.data.in_chan1, req_if.data.in_chan0};
               if (req_if.data.frame_start) begin
                  // A new frame restarts every position counter at this pixel.
                  src_col_in = '0;
                  src_row_in = '0;
                  grp_row_in = '0;
                  grp_acc_in = '0;
                  ndc_in     = '0;
                  col_acc_in = '0;
                  cur_c_in   = '0;
                  cur_r_in   = '0;
               end else begin
                  // A column past the row end counts as the last column.
                  cur_c_in = (14'(src_col_ff) > sw_m1) ? sw_m1[LineAw-1:0] : src_col_ff;
                  cur_r_in = src_row_ff;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            tap_up_c_in   = mem_rd_a[PixW-1:0];
            tap_up_cm1_in = mem_rd_b[EntryW-1:PixW];
            tap_lo_cm1_in = mem_rd_b[PixW-1:0];
            wa_in         = col_acc_ff;
            wk_in         = '0;
            wdy_in        = grp_row_ff;
            wra_in        = grp_acc_ff;
            wj_in         = '0;
            wca_in        = col_acc_ff;
            wn_in         = '0;
            state_in      = (cur_c_ff == '0) ? ST_COMMIT : ST_COLS;
         end
         ST_COLS: begin
            if (col_cond) begin
               wk_in = wk_ff + 13'd1;
               wa_in = acc_add(wa_ff, cfg.col_step);
            end else if ((wk_ff != '0) && row_cond) begin
               state_in = ST_EMIT_H;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_EMIT_H: begin
            // Horizontal pass for both tap rows, plus the look-ahead for last_of_run.
            for (int ch = 0; ch < 3; ch++) begin
               ht_in[ch] = blend(pick_chan(top_cm1, sel[ch]), pick_chan(top_c, sel[ch]),
                                 wca_ff[15:8]);
               hb_in[ch] = blend(pick_chan(tap_lo_cm1_ff, sel[ch]), pick_chan(px_ff, sel[ch]),
                                 wca_ff[15:8]);
            end
            wy_in       = wra_ff[15:8];
            dcol_in     = PosW'(ndc_ff + wj_ff);
            drow_in     = wdy_ff[PosW-1:0];
            col_more_in = (wj_ff + 13'd1) < wk_ff;
            more_in     = ((wn_ff + FanW'(1)) < FanMax)
                          && (((wj_ff + 13'd1) < wk_ff) || row_more);
            ra_n_in     = ra_step;
            state_in    = ST_EMIT_V;
         end
         ST_EMIT_V: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.dest_col  = dcol_ff;
               rsp_data_in.dest_row  = drow_ff;
               rsp_data_in.out_chan0 = blend(ht_ff[0], hb_ff[0], wy_ff);
               rsp_data_in.out_chan1 = blend(ht_ff[1], hb_ff[1], wy_ff);
               rsp_data_in.out_chan2 = blend(ht_ff[2], hb_ff[2], wy_ff);
               rsp_data_in.last_of_run = !more_ff;
               wn_in = wn_ff + FanW'(1);
               if (!more_ff) begin
                  state_in = ST_COMMIT;
               end else if (col_more_ff) begin
                  wj_in    = wj_ff + 13'd1;
                  wca_in   = acc_add(wca_ff, cfg.col_step);
                  state_in = ST_EMIT_H;
               end else begin
                  wdy_in   = wdy_ff + 13'd1;
                  wra_in   = ra_n_ff;
                  wj_in    = '0;
                  wca_in   = col_acc_ff;
                  state_in = ST_EMIT_H;
               end
            end
         end
         ST_COMMIT: begin
            ndc_in     = ndc_ff + wk_ff;
            col_acc_in = wa_ff;
            if (c_ext == sw_m1) begin
               wdy_in   = grp_row_ff;
               wra_in   = grp_acc_ff;
               state_in = ST_FINISH;
            end else begin
               src_col_in = cur_c_ff + LineAw'(1);
               state_in   = ST_IDLE;
            end
         end
         ST_FINISH: begin
            // Close every destination row whose lower tap row is now complete.
            if (row_cond) begin
               wdy_in = wdy_ff + 13'd1;
               wra_in = ra_step;
            end else begin
               grp_row_in = wdy_ff;
               grp_acc_in = wra_ff;
               src_row_in = (cur_r_ff < RowCountMax) ? cur_r_ff + 12'd1 : RowCountMax;
               src_col_in = '0;
               ndc_in     = '0;
               col_acc_in = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         grp_row_ff   <= '0;
         grp_acc_ff   <= '0;
         ndc_ff       <= '0;
         col_acc_ff   <= '0;
         wn_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         grp_row_ff   <= grp_row_in;
         grp_acc_ff   <= grp_acc_in;
         ndc_ff       <= ndc_in;
         col_acc_ff   <= col_acc_in;
         wn_ff        <= wn_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      cur_c_ff      <= cur_c_in;
      cur_r_ff      <= cur_r_in;
      wa_ff         <= wa_in;
      wk_ff         <= wk_in;
      wdy_ff        <= wdy_in;
      wra_ff        <= wra_in;
      wj_ff         <= wj_in;
      wca_ff        <= wca_in;
      tap_up_c_ff   <= tap_up_c_in;
      tap_up_cm1_ff <= tap_up_cm1_in;
      tap_lo_cm1_ff <= tap_lo_cm1_in;
      wy_ff         <= wy_in;
      dcol_ff       <= dcol_in;
      drow_ff       <= drow_in;
      more_ff       <= more_in;
      col_more_ff   <= col_more_in;
      ra_n_ff       <= ra_n_in;
      rsp_data_ff   <= rsp_data_in;
      for (int ch = 0; ch < 3; ch++) begin
         ht_ff[ch] <= ht_in[ch];
         hb_ff[ch] <= hb_in[ch];
      end
   end

   // An accepted request always starts with the line store read.
   `BSS_ASSERT_NXT(a_accept_reads, clock, reset, req_fire, state_ff == ST_READ, "read skipped")
   // The per-request result count never passes the fanout limit.
   `BSS_ASSERT_IMP(a_fanout_cap, clock, reset, 1'b1, wn_ff <= FanMax, "fanout exceeded")
   // The first column of a row never advances destination columns.
   `BSS_ASSERT_IMP(a_first_col, clock, reset, (state_ff == ST_COMMIT) && (cur_c_ff == '0),
      wk_ff == '0, "column advance at column zero")

endmodule

`default_nettype wire
